### design/i2c_mbe_pkg.sv
// Shared types and codes for the I2C master byte engine.
package i2c_mbe_pkg;

	// Input command codes
	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_STOP   = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_READ   = 3'd3,
		CMD_SAMPLE = 3'd4
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_STEP  = 2'd0,
		ST_ACK   = 2'd1,
		ST_NOACK = 2'd2,
		ST_BYTE  = 2'd3
	} status_t;

	// Front-end bus mode
	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_ACKWAIT = 2'd1,
		MODE_READ    = 2'd2
	} mode_t;

	// Pin sequences carried out by the back end
	typedef enum logic [2:0] {
		JOB_START    = 3'd0,
		JOB_STOP     = 3'd1,
		JOB_WRITE    = 3'd2,
		JOB_RD_BEGIN = 3'd3,
		JOB_RD_BIT   = 3'd4,
		JOB_RD_LAST  = 3'd5,
		JOB_ACK_LOW  = 3'd6
	} job_kind_t;

	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd50;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic       send_ack;
		logic       sda_level;
	} in_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic [1:0] status;
		logic [7:0] read_data;
		logic       last;
	} out_item_t;

	// One queued pin sequence
	typedef struct packed {
		job_kind_t kind;
		logic [7:0] data;
		logic       ack;
		status_t    status;
	} job_t;

endpackage

### design/i2c_mbe_front.sv
// Front end: accepts items, tracks bus mode, classifies items into pin jobs.
module i2c_mbe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  i2c_mbe_pkg::in_item_t in_item,
	input  logic                  cfg_wr_en,
	input  logic [7:0]            cfg_wr_data,
	input  logic                  jq_full,
	output logic                  job_valid,
	output i2c_mbe_pkg::job_t     job
);
	import i2c_mbe_pkg::*;

	mode_t      mode_q, mode_d;
	logic [7:0] timeout_q;
	logic [7:0] hc_q, hc_d, hc_inc;
	logic [2:0] bi_q, bi_d;
	logic [7:0] sh_q, sh_d, sh_new;
	logic       pa_q, pa_d;
	logic       accept;

	assign full   = jq_full;
	assign accept = push & ~jq_full;
	assign hc_inc = (hc_q == 8'hFF) ? hc_q : hc_q + 8'd1;
	assign sh_new = {sh_q[6:0], in_item.sda_level};

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// Mode and per-transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hc_q   <= '0;
			bi_q   <= '0;
			sh_q   <= '0;
			pa_q   <= 1'b0;
		end else begin
			mode_q <= mode_d;
			hc_q   <= hc_d;
			bi_q   <= bi_d;
			sh_q   <= sh_d;
			pa_q   <= pa_d;
		end
	end

	// Next state and job classification
	always_comb begin
		mode_d    = mode_q;
		hc_d      = hc_q;
		bi_d      = bi_q;
		sh_d      = sh_q;
		pa_d      = pa_q;
		job_valid = 1'b0;
		job       = '{kind: JOB_START, data: 8'd0, ack: 1'b0, status: ST_STEP};
		if (accept) begin
			if (in_item.command == CMD_SAMPLE) begin
				unique case (mode_q)
					MODE_ACKWAIT: begin
						if (!in_item.sda_level) begin
							job_valid  = 1'b1;
							job.kind   = JOB_ACK_LOW;
							job.status = ST_ACK;
							mode_d     = MODE_IDLE;
							hc_d       = '0;
						end else if (hc_inc > timeout_q) begin
							job_valid  = 1'b1;
							job.kind   = JOB_STOP;
							job.status = ST_NOACK;
							mode_d     = MODE_IDLE;
							hc_d       = '0;
						end else begin
							hc_d = hc_inc;
						end
					end
					MODE_READ: begin
						sh_d      = sh_new;
						job_valid = 1'b1;
						if (bi_q == 3'd7) begin
							job.kind   = JOB_RD_LAST;
							job.data   = sh_new;
							job.ack    = pa_q;
							job.status = ST_BYTE;
							mode_d     = MODE_IDLE;
							bi_d       = '0;
						end else begin
							job.kind = JOB_RD_BIT;
							bi_d     = bi_q + 3'd1;
						end
					end
					default: ;
				endcase
			end else if (mode_q == MODE_IDLE) begin
				unique case (in_item.command)
					CMD_START: begin
						job_valid = 1'b1;
						job.kind  = JOB_START;
					end
					CMD_STOP: begin
						job_valid = 1'b1;
						job.kind  = JOB_STOP;
					end
					CMD_WRITE: begin
						job_valid = 1'b1;
						job.kind  = JOB_WRITE;
						job.data  = in_item.data_byte;
						mode_d    = MODE_ACKWAIT;
						hc_d      = '0;
					end
					CMD_READ: begin
						job_valid = 1'b1;
						job.kind  = JOB_RD_BEGIN;
						mode_d    = MODE_READ;
						bi_d      = '0;
						sh_d      = '0;
						pa_d      = in_item.send_ack;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

### design/i2c_mbe_jobq.sv
// Small job queue between the front end and the pin sequencer.
module i2c_mbe_jobq #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  i2c_mbe_pkg::job_t wr_job,
	output logic              full,
	input  logic              rd_en,
	output logic              rd_valid,
	output i2c_mbe_pkg::job_t rd_job
);
	import i2c_mbe_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	job_t          slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = slots_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Slot storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

### design/i2c_mbe_back.sv
// Back end: expands jobs into SCL/SDA pin steps, one step per cycle unless the result stalls.
module i2c_mbe_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   jq_valid,
	input  i2c_mbe_pkg::job_t      jq_job,
	output logic                   jq_pop,
	output logic                   empty,
	input  logic                   pop,
	output i2c_mbe_pkg::out_item_t result
);
	import i2c_mbe_pkg::*;

	job_t      job_q;
	logic      busy_q;
	logic [2:0] ph_q;
	logic [3:0] bits_q;
	logic      scl_q, sda_q;
	logic      out_valid_q;
	out_item_t out_q;

	logic      sets_sda, pin_val, step_last;
	logic      adv, load, shift_now;
	out_item_t step;

	assign adv       = busy_q & (~out_valid_q | pop);
	assign load      = jq_valid & (~busy_q | (adv & step_last));
	assign jq_pop    = load;
	assign shift_now = adv & ~step_last & (job_q.kind == JOB_WRITE) & ~bits_q[3] & (ph_q == 3'd2);
	assign empty     = ~out_valid_q;
	assign result    = out_q;

	// Pin step decode for the current job and phase
	always_comb begin
		sets_sda  = 1'b0;
		pin_val   = 1'b0;
		step_last = 1'b0;
		unique case (job_q.kind)
			JOB_START: begin
				case (ph_q)
					3'd0: begin sets_sda = 1'b1; pin_val = 1'b1; end
					3'd1: begin pin_val = 1'b1; end
					3'd2: begin sets_sda = 1'b1; end
					default: step_last = 1'b1;
				endcase
			end
			JOB_STOP: begin
				case (ph_q)
					3'd0: sets_sda = 1'b1;
					3'd1: pin_val = 1'b1;
					default: begin sets_sda = 1'b1; pin_val = 1'b1; step_last = 1'b1; end
				endcase
			end
			JOB_WRITE: begin
				if (!bits_q[3]) begin
					case (ph_q)
						3'd0: begin sets_sda = 1'b1; pin_val = job_q.data[7]; end
						3'd1: pin_val = 1'b1;
						default: ;
					endcase
				end else if (ph_q == 3'd0) begin
					sets_sda = 1'b1;
					pin_val  = 1'b1;
				end else begin
					pin_val   = 1'b1;
					step_last = 1'b1;
				end
			end
			JOB_RD_BEGIN: begin
				if (ph_q == 3'd0) begin
					sets_sda = 1'b1;
					pin_val  = 1'b1;
				end else begin
					pin_val   = 1'b1;
					step_last = 1'b1;
				end
			end
			JOB_RD_BIT: begin
				if (ph_q != 3'd0) begin
					pin_val   = 1'b1;
					step_last = 1'b1;
				end
			end
			JOB_RD_LAST: begin
				case (ph_q)
					3'd0, 3'd1: ;
					3'd2: begin sets_sda = 1'b1; pin_val = ~job_q.ack; end
					3'd3: pin_val = 1'b1;
					default: step_last = 1'b1;
				endcase
			end
			JOB_ACK_LOW: step_last = 1'b1;
			default: step_last = 1'b1;
		endcase
	end

	// Result item for this step
	always_comb begin
		step.scl_out   = sets_sda ? scl_q : pin_val;
		step.sda_out   = sets_sda ? pin_val : sda_q;
		step.status    = step_last ? job_q.status : ST_STEP;
		step.read_data = (step_last && job_q.kind == JOB_RD_LAST) ? job_q.data : 8'd0;
		step.last      = step_last;
	end

	// Sequencer control and pin levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ph_q        <= '0;
			bits_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				if (sets_sda) begin
					sda_q <= pin_val;
				end else begin
					scl_q <= pin_val;
				end
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
				bits_q <= '0;
			end else if (adv && step_last) begin
				busy_q <= 1'b0;
			end else if (shift_now) begin
				ph_q   <= '0;
				bits_q <= bits_q + 4'd1;
			end else if (adv) begin
				ph_q <= ph_q + 3'd1;
			end
		end
	end

	// Job and output payload
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= jq_job;
		end else if (shift_now) begin
			job_q.data <= {job_q.data[6:0], 1'b0};
		end
		if (adv) begin
			out_q <= step;
		end
	end

endmodule

### design/i2c_master_byte_engine_unit.sv
// Top level of the I2C master byte engine.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------
//  input    | push / full        | in_item (command, byte, ack, sda)
//  result   | empty / pop        | result (scl, sda, status, data, last)
//  config   | cfg_wr_en          | cfg_wr_data (ack timeout)
//
// The front end takes one item per cycle while the job queue has room;
// items that cause no pin step are accepted the same way.
// The pin sequencer emits one pin step per cycle while results are taken;
// a write byte is 26 steps, start 4, stop 3, a read sample 2 (the eighth 5).
// Reset sets the ack timeout to 50, both pins high, bus mode idle.
// A stalled result holds the sequencer; the front end keeps accepting
// until the job queue fills.
module i2c_master_byte_engine_unit #(
	parameter int JOBQ_DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  i2c_mbe_pkg::in_item_t  in_item,
	output logic                   empty,
	input  logic                   pop,
	output i2c_mbe_pkg::out_item_t result,
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data
);
	import i2c_mbe_pkg::*;

	logic jq_full, jq_valid, jq_pop, job_valid;
	job_t job, jq_job;

	i2c_mbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.jq_full    (jq_full),
		.job_valid  (job_valid),
		.job        (job)
	);

	i2c_mbe_jobq #(.DEPTH(JOBQ_DEPTH)) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_job  (job),
		.full    (jq_full),
		.rd_en   (jq_pop),
		.rd_valid(jq_valid),
		.rd_job  (jq_job)
	);

	i2c_mbe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.jq_valid(jq_valid),
		.jq_job  (jq_job),
		.jq_pop  (jq_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

### design/i2c_mbe_checker.sv
// Port-level checks for the I2C master byte engine, bound to the top level.
module i2c_mbe_port_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   empty,
	input logic                   pop,
	input i2c_mbe_pkg::out_item_t result
);
	import i2c_mbe_pkg::*;

	// A waiting item holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result item changed while stalled");

	// Only the final step of a sequence carries a status
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != ST_STEP |-> result.last)
		else $error("status on a non-final step");

	// Read data only appears with a byte-read status
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status != ST_BYTE |-> result.read_data == 8'd0)
		else $error("read data without byte-read status");

	// An ack ends with SCL low
	a_ack_scl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_ACK |-> !result.scl_out)
		else $error("ack step with SCL high");

	// A timeout ends in a stop: both lines released
	a_noack_stop: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == ST_NOACK |-> result.scl_out && result.sda_out)
		else $error("no-ack without stop condition");

endmodule

bind i2c_master_byte_engine_unit i2c_mbe_port_checker u_chk (.*);
